// ----- hdl/gps_week_time_ntp_stamper_core_defines.svh -----
// Assertion macros shared by the GPS week time stamper RTL.
`ifndef GPS_WEEK_TIME_NTP_STAMPER_CORE_DEFINES_SVH
`define GPS_WEEK_TIME_NTP_STAMPER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GWT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/gwt_pkg.sv -----
// Shared types and constants of the GPS week time stamper.
`default_nettype none

package gwt_pkg;

   localparam logic [1:0] REQ_SET_DATE = 2'd0;
   localparam logic [1:0] REQ_TICK     = 2'd1;
   localparam logic [1:0] REQ_NTP      = 2'd2;
   localparam logic [1:0] REQ_UNIX     = 2'd3;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NTP_OFFSET = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUND_BIAS = 1'b1;

   localparam logic [31:0] NTP_OFFSET_RESET = 32'd0;
   localparam logic [15:0] ROUND_BIAS_RESET = 16'd32768;

   localparam logic [19:0] WEEK_SECONDS   = 20'd604800;
   localparam logic [31:0] GPS_NTP_EPOCH  = 32'd2524953600;
   localparam logic [31:0] GPS_UNIX_EPOCH = 32'd315964800;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   typedef struct packed {
      logic        is_ntp;
      logic [15:0] week;
      logic [19:0] sow;
      logic [31:0] timer;
      logic [31:0] fudge;
   } query_type;

endpackage

`default_nettype wire

// ----- hdl/gwt_queue.sv -----
// Short queue of query items between the front and back parts.
`default_nettype none
`include "gps_week_time_ntp_stamper_core_defines.svh"

module gwt_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_en,
   input  gwt_pkg::query_type      push_item,
   output logic                    full,
   input  wire logic               pop_en,
   output gwt_pkg::query_type      pop_item,
   output logic                    empty
);

   gwt_pkg::query_type mem_ff [gwt_pkg::QUEUE_DEPTH];
   logic [gwt_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gwt_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gwt_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full     = (count_ff == gwt_pkg::QUEUE_CNT_W'(gwt_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push_en && !full;
   assign do_pop   = pop_en && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `GWT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= gwt_pkg::QUEUE_CNT_W'(gwt_pkg::QUEUE_DEPTH), "Queue count exceeds its depth.")
   `GWT_ASSERT_SAME(a_pop_nonempty, clock, reset, pop_en, !empty, "Queue popped while empty.")

endmodule

`default_nettype wire

// ----- hdl/gwt_front.sv -----
// Front part: accepts items, keeps week and second of week, forwards queries.
`default_nettype none
`include "gps_week_time_ntp_stamper_core_defines.svh"

module gwt_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire logic [1:0]         req_type,
   input  wire logic [15:0]        req_week_in,
   input  wire logic [19:0]        req_tow_in,
   input  wire logic signed [7:0]  req_utc_offset,
   input  wire logic [31:0]        req_timer_count,
   input  wire logic signed [31:0] req_fudge,
   input  wire logic               q_full,
   output logic                    q_push,
   output gwt_pkg::query_type      q_item
);

   logic [15:0] week_ff, week_in;
   logic [19:0] sow_ff, sow_in;
   logic        accept;
   logic [21:0] sd_sum;
   logic [21:0] sd_wrap;
   logic [20:0] tick_sum;
   logic        tick_roll;

   assign accept    = req_push && !q_full;
   assign sd_sum    = {2'b00, req_tow_in} + {{14{req_utc_offset[7]}}, req_utc_offset};
   assign sd_wrap   = sd_sum + {2'b00, gwt_pkg::WEEK_SECONDS};
   assign tick_sum  = {1'b0, sow_ff} + 21'd1;
   assign tick_roll = (tick_sum >= {1'b0, gwt_pkg::WEEK_SECONDS});

   always_comb begin
      week_in = week_ff;
      sow_in  = sow_ff;
      q_push  = 1'b0;
      if (accept) begin
         unique case (req_type) inside
            gwt_pkg::REQ_SET_DATE: begin
               if (sd_sum[21]) begin
                  sow_in  = sd_wrap[19:0];
                  week_in = req_week_in - 16'd1;
               end else begin
                  sow_in  = sd_sum[19:0];
                  week_in = req_week_in;
               end
            end
            gwt_pkg::REQ_TICK: begin
               if (tick_roll) begin
                  sow_in  = 20'(tick_sum - {1'b0, gwt_pkg::WEEK_SECONDS});
                  week_in = week_ff + 16'd1;
               end else begin
                  sow_in = tick_sum[19:0];
               end
            end
            gwt_pkg::REQ_NTP, gwt_pkg::REQ_UNIX: begin
               q_push = 1'b1;
            end
            default: begin
               q_push = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      q_item.is_ntp = (req_type == gwt_pkg::REQ_NTP);
      q_item.week   = week_ff;
      q_item.sow    = sow_ff;
      q_item.timer  = req_timer_count;
      q_item.fudge  = $unsigned(req_fudge);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         week_ff <= '0;
         sow_ff  <= '0;
      end else begin
         week_ff <= week_in;
         sow_ff  <= sow_in;
      end
   end

   `GWT_ASSERT_NEXT(a_tick_step, clock, reset, accept && (req_type == gwt_pkg::REQ_TICK) && (sow_ff < 20'd604799), (sow_ff == $past(sow_ff) + 20'd1) && (week_ff == $past(week_ff)), "Tick did not advance the second by one.")

endmodule

`default_nettype wire

// ----- hdl/gwt_back.sv -----
// Back part: scales timer captures and forms NTP and Unix time stamps.
`default_nettype none
`include "gps_week_time_ntp_stamper_core_defines.svh"

module gwt_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [31:0]                     scale_int,
   input  wire logic [31:0]                     scale_frac,
   input  wire logic                            csr_write_en,
   input  wire logic [gwt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                     csr_wdata,
   input  wire logic                            q_empty,
   input  gwt_pkg::query_type                   q_item,
   output logic                                 q_pop,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [31:0]                          rsp_ntp_seconds,
   output logic [31:0]                          rsp_ntp_fraction,
   output logic signed [31:0]                   rsp_unix_seconds
);

   logic [31:0] offset_ff;
   logic [15:0] bias_ff;

   logic        s1_v_ff, s1_v_in;
   logic        s1_ntp_ff;
   logic [31:0] s1_int_ff, s1_hi_ff, s1_x1_ff, s1_x2_ff, s1_lo_ff, s1_week_ff;
   logic [19:0] s1_sow_ff;
   logic [31:0] s1_fudge_ff;

   logic        s2_v_ff, s2_v_in;
   logic        s2_ntp_ff;
   logic [31:0] s2_pre_ff, s2_mid_ff, s2_base_ff, s2_adj_ff;

   logic        s3_v_ff, s3_v_in;
   logic [31:0] s3_secs_ff, s3_frac_ff, s3_unix_ff;

   logic s1_ready, s2_ready, s3_ready;
   logic [15:0] th, tl, mh, ml;
   logic [31:0] mid_sum;
   logic [31:0] frac, aug, secs;

   assign s3_ready = !s3_v_ff || rsp_pop;
   assign s2_ready = !s2_v_ff || s3_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign q_pop    = !q_empty && s1_ready;

   assign s1_v_in = s1_ready ? !q_empty : s1_v_ff;
   assign s2_v_in = s2_ready ? s1_v_ff : s2_v_ff;
   assign s3_v_in = s3_ready ? s2_v_ff : s3_v_ff;

   assign th = q_item.timer[31:16];
   assign tl = q_item.timer[15:0];
   assign mh = scale_frac[31:16];
   assign ml = scale_frac[15:0];

   assign mid_sum = s1_x1_ff + s1_x2_ff + {16'd0, s1_lo_ff[31:16]} + {16'd0, bias_ff};
   assign frac    = s2_pre_ff + s2_mid_ff;
   assign aug     = frac + s2_adj_ff;
   assign secs    = s2_base_ff + {31'd0, (aug < frac)};

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= gwt_pkg::NTP_OFFSET_RESET;
         bias_ff   <= gwt_pkg::ROUND_BIAS_RESET;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
      end else begin
         if (csr_write_en && (csr_index == gwt_pkg::CSR_NTP_OFFSET)) begin
            offset_ff <= csr_wdata;
         end
         if (csr_write_en && (csr_index == gwt_pkg::CSR_ROUND_BIAS)) begin
            bias_ff <= csr_wdata[15:0];
         end
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ntp_ff   <= q_item.is_ntp;
         s1_int_ff   <= 32'(q_item.timer * scale_int);
         s1_hi_ff    <= 32'(th) * 32'(mh);
         s1_x1_ff    <= 32'(th) * 32'(ml);
         s1_x2_ff    <= 32'(tl) * 32'(mh);
         s1_lo_ff    <= 32'(tl) * 32'(ml);
         s1_week_ff  <= 32'(32'(q_item.week) * 32'(gwt_pkg::WEEK_SECONDS));
         s1_sow_ff   <= q_item.sow;
         s1_fudge_ff <= q_item.fudge;
      end
      if (s2_ready) begin
         s2_ntp_ff  <= s1_ntp_ff;
         s2_pre_ff  <= s1_int_ff + s1_hi_ff;
         s2_mid_ff  <= {16'd0, mid_sum[31:16]};
         s2_base_ff <= (s1_ntp_ff ? gwt_pkg::GPS_NTP_EPOCH : gwt_pkg::GPS_UNIX_EPOCH)
                       + s1_week_ff + {12'd0, s1_sow_ff};
         s2_adj_ff  <= s1_fudge_ff + offset_ff;
      end
      if (s3_ready) begin
         s3_secs_ff <= s2_ntp_ff ? secs : 32'd0;
         s3_frac_ff <= s2_ntp_ff ? aug : 32'd0;
         s3_unix_ff <= s2_ntp_ff ? 32'd0 : s2_base_ff;
      end
   end

   assign rsp_empty        = !s3_v_ff;
   assign rsp_ntp_seconds  = s3_secs_ff;
   assign rsp_ntp_fraction = s3_frac_ff;
   assign rsp_unix_seconds = $signed(s3_unix_ff);

   `GWT_ASSERT_SAME(a_unix_excl, clock, reset, s3_v_ff && (s3_unix_ff != 32'd0), (s3_secs_ff == 32'd0) && (s3_frac_ff == 32'd0), "Unix result carries NTP fields.")

endmodule

`default_nettype wire

// ----- hdl/gps_week_time_ntp_stamper_core.sv -----
// Top level of the GPS week time stamper with NTP and Unix time stamps.
//
// Items enter through a queue-like port: an item is taken at a clock edge
// with req_push high and req_full low. Set-date and tick items update the
// GPS week and UTC second of week at once and give no result. NTP and Unix
// queries capture the time held at acceptance and each give one result.
// Results leave through a queue-like port: the oldest result is shown while
// rsp_empty is low and is taken at an edge with rsp_pop high.
// A query's result passes from the query queue through the s1, s2 and s3
// registers of the three-stage scaling pipeline. One item per cycle is taken
// in steady state while results are popped; the query queue holds four entries.
// When the receiver stalls, the pipeline holds and the query queue fills;
// req_full then rises and stays high until results are popped again.
// Reset clears the time to week zero, second zero, empties the queue and
// pipeline, and sets the NTP offset to zero and the rounding bias to 32768.
// The configuration port writes a register at each edge with csr_write_en.
`default_nettype none

module gps_week_time_ntp_stamper_core #(
   parameter int unsigned CLOCK_HZ = 42000000
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [1:0]                      req_type,
   input  wire logic [15:0]                     req_week_in,
   input  wire logic [19:0]                     req_tow_in,
   input  wire logic signed [7:0]               req_utc_offset,
   input  wire logic [31:0]                     req_timer_count,
   input  wire logic signed [31:0]              req_fudge,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [31:0]                          rsp_ntp_seconds,
   output logic [31:0]                          rsp_ntp_fraction,
   output logic signed [31:0]                   rsp_unix_seconds,
   input  wire logic                            csr_write_en,
   input  wire logic [gwt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                     csr_wdata
);

   localparam logic [63:0] TWO32      = 64'd1 << 32;
   localparam logic [63:0] HZ         = 64'(CLOCK_HZ);
   localparam logic [63:0] MI_WIDE    = TWO32 / HZ;
   localparam logic [63:0] MF_WIDE    = ((TWO32 - MI_WIDE * HZ) * TWO32) / HZ;
   localparam logic [31:0] SCALE_INT  = MI_WIDE[31:0];
   localparam logic [31:0] SCALE_FRAC = MF_WIDE[31:0];

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   gwt_pkg::query_type q_push_item;
   gwt_pkg::query_type q_pop_item;

   assign req_full = q_full;

   gwt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_type        (req_type),
      .req_week_in     (req_week_in),
      .req_tow_in      (req_tow_in),
      .req_utc_offset  (req_utc_offset),
      .req_timer_count (req_timer_count),
      .req_fudge       (req_fudge),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_push_item)
   );

   gwt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop_en    (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   gwt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .scale_int        (SCALE_INT),
      .scale_frac       (SCALE_FRAC),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_empty          (q_empty),
      .q_item           (q_pop_item),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_ntp_seconds  (rsp_ntp_seconds),
      .rsp_ntp_fraction (rsp_ntp_fraction),
      .rsp_unix_seconds (rsp_unix_seconds)
   );

endmodule

`default_nettype wire
